>>> rtl/mvna_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mvna_pkg;

   localparam int MAX_VERTICES = 4096;

   localparam int IdxW    = 12;
   localparam int IdxExtW = 17;
   localparam int VtxAw   = $clog2(MAX_VERTICES);
   localparam int PosW    = 24;
   localparam int DiffW   = PosW + 1;
   localparam int ProdW   = 2 * DiffW;
   localparam int CrossW  = ProdW + 1;
   localparam int NormW   = 48;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_TRI  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // -100 in Q32.16
   localparam logic signed [NormW-1:0] NORM_SENTINEL = -48'sd6553600;

   typedef struct packed {
      logic [1:0]             opcode;
      logic [IdxW-1:0]        first_index;
      logic [IdxW-1:0]        second_index;
      logic [IdxW-1:0]        third_index;
      logic signed [PosW-1:0] pos_x;
      logic signed [PosW-1:0] pos_y;
      logic signed [PosW-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [NormW-1:0] normal_x;
      logic signed [NormW-1:0] normal_y;
      logic signed [NormW-1:0] normal_z;
   } rsp_type;

   typedef struct packed {
      logic signed [PosW-1:0] x;
      logic signed [PosW-1:0] y;
      logic signed [PosW-1:0] z;
   } vtx_type;

   typedef struct packed {
      logic signed [DiffW-1:0] x;
      logic signed [DiffW-1:0] y;
      logic signed [DiffW-1:0] z;
   } diff_type;

   typedef struct packed {
      logic signed [ProdW-1:0] yz;
      logic signed [ProdW-1:0] zy;
      logic signed [ProdW-1:0] zx;
      logic signed [ProdW-1:0] xz;
      logic signed [ProdW-1:0] xy;
      logic signed [ProdW-1:0] yx;
   } prod_type;

   typedef struct packed {
      logic signed [NormW-1:0] x;
      logic signed [NormW-1:0] y;
      logic signed [NormW-1:0] z;
   } norm_type;

   function automatic logic signed [NormW-1:0] sat_norm(input logic signed [CrossW-1:0] v);
      logic [CrossW-NormW:0] top;
      logic signed [NormW-1:0] res;
      top = v[CrossW-1:NormW-1];
      if ((&top) || !(|top)) begin
         res = v[NormW-1:0];
      end else if (v[CrossW-1]) begin
         res = {1'b1, {(NormW-1){1'b0}}};
      end else begin
         res = {1'b0, {(NormW-1){1'b1}}};
      end
      return res;
   endfunction

   function automatic logic in_range(input logic [IdxW-1:0] idx);
      logic [IdxExtW-1:0] ext;
      ext = IdxExtW'(idx);
      return ext < IdxExtW'(MAX_VERTICES);
   endfunction

   function automatic logic [VtxAw-1:0] to_addr(input logic [IdxW-1:0] idx);
      logic [IdxExtW-1:0] ext;
      ext = IdxExtW'(idx);
      return ext[VtxAw-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/mvna_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mvna_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/mesh_vertex_normal_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Payload   Accepted when
// req      in         req_type  req_valid && req_ready
// rsp      out        rsp_type  rsp_valid && rsp_ready
//
// One item at a time. A normal read waits while the result register is full.
// A triangle takes three vertex reads, the difference/multiply/subtract
// stages and three normal read-modify-writes on the normal memory, whose
// read and write ports share one address.
// Reset is synchronous; the memories are not cleared.
// req_ready is low from acceptance until the item's work is done.
module mesh_vertex_normal_accumulator
   import mvna_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_DEC, S_VRD2, S_VRD3, S_DIFF, S_MUL, S_CROSS, S_NRD, S_NWR, S_RRSP
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [1:0] corner_ff, corner_in;
   vtx_type   v1_ff, v1_in, v2_ff, v2_in;
   diff_type  a_ff, a_in, b_ff, b_in;
   prod_type  prod_ff, prod_in;
   norm_type  cross_ff, cross_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   logic             vtx_wr_en;
   logic [VtxAw-1:0] vtx_rd_addr;
   logic [$bits(vtx_type)-1:0] vtx_rd_raw;
   vtx_type          vtx_rd;
   vtx_type          vtx_wr;

   logic             nrm_wr_en;
   logic [VtxAw-1:0] nrm_addr;
   logic [$bits(norm_type)-1:0] nrm_rd_raw;
   norm_type         nrm_rd;
   norm_type         nrm_wr;
   norm_type         nrm_upd;
   logic [IdxW-1:0]  corner_idx;
   logic             unset;

   assign vtx_rd = vtx_type'(vtx_rd_raw);
   assign nrm_rd = norm_type'(nrm_rd_raw);
   assign vtx_wr = '{x: req_ff.pos_x, y: req_ff.pos_y, z: req_ff.pos_z};

   always_comb begin
      case (corner_ff)
         2'd0:    corner_idx = req_ff.first_index;
         2'd1:    corner_idx = req_ff.second_index;
         default: corner_idx = req_ff.third_index;
      endcase
   end

   always_comb begin
      case (state_ff)
         S_VRD2:  vtx_rd_addr = to_addr(req_ff.second_index);
         S_VRD3:  vtx_rd_addr = to_addr(req_ff.third_index);
         default: vtx_rd_addr = to_addr(req_ff.first_index);
      endcase
   end

   assign nrm_addr = (state_ff == S_DEC || state_ff == S_RRSP) ?
                     to_addr(req_ff.first_index) : to_addr(corner_idx);

   // An unset normal takes the cross product as is; otherwise add and clamp.
   assign unset = (nrm_rd.x == NORM_SENTINEL) && (nrm_rd.y == NORM_SENTINEL) &&
                  (nrm_rd.z == NORM_SENTINEL);
   always_comb begin
      if (unset) begin
         nrm_upd = cross_ff;
      end else begin
         nrm_upd.x = sat_norm(CrossW'(nrm_rd.x) + CrossW'(cross_ff.x));
         nrm_upd.y = sat_norm(CrossW'(nrm_rd.y) + CrossW'(cross_ff.y));
         nrm_upd.z = sat_norm(CrossW'(nrm_rd.z) + CrossW'(cross_ff.z));
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      corner_in    = corner_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      prod_in      = prod_ff;
      cross_in     = cross_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      vtx_wr_en    = 1'b0;
      nrm_wr_en    = 1'b0;
      nrm_wr       = nrm_upd;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            corner_in = 2'd0;
            case (req_ff.opcode)
               OP_LOAD: begin
                  if (in_range(req_ff.first_index)) begin
                     vtx_wr_en = 1'b1;
                     nrm_wr_en = 1'b1;
                     nrm_wr    = '{x: NORM_SENTINEL, y: NORM_SENTINEL, z: NORM_SENTINEL};
                  end
                  state_in = S_IDLE;
               end
               OP_TRI: begin
                  if (in_range(req_ff.first_index) && in_range(req_ff.second_index) &&
                      in_range(req_ff.third_index)) begin
                     state_in = S_VRD2;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               OP_READ: state_in = S_RRSP;
               default: state_in = S_IDLE;
            endcase
         end
         S_VRD2: begin
            v1_in    = vtx_rd;
            state_in = S_VRD3;
         end
         S_VRD3: begin
            v2_in    = vtx_rd;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            a_in.x   = DiffW'(v2_ff.x) - DiffW'(v1_ff.x);
            a_in.y   = DiffW'(v2_ff.y) - DiffW'(v1_ff.y);
            a_in.z   = DiffW'(v2_ff.z) - DiffW'(v1_ff.z);
            b_in.x   = DiffW'(vtx_rd.x) - DiffW'(v1_ff.x);
            b_in.y   = DiffW'(vtx_rd.y) - DiffW'(v1_ff.y);
            b_in.z   = DiffW'(vtx_rd.z) - DiffW'(v1_ff.z);
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in.yz = ProdW'(a_ff.y) * ProdW'(b_ff.z);
            prod_in.zy = ProdW'(a_ff.z) * ProdW'(b_ff.y);
            prod_in.zx = ProdW'(a_ff.z) * ProdW'(b_ff.x);
            prod_in.xz = ProdW'(a_ff.x) * ProdW'(b_ff.z);
            prod_in.xy = ProdW'(a_ff.x) * ProdW'(b_ff.y);
            prod_in.yx = ProdW'(a_ff.y) * ProdW'(b_ff.x);
            state_in   = S_CROSS;
         end
         S_CROSS: begin
            cross_in.x = sat_norm(CrossW'(prod_ff.yz) - CrossW'(prod_ff.zy));
            cross_in.y = sat_norm(CrossW'(prod_ff.zx) - CrossW'(prod_ff.xz));
            cross_in.z = sat_norm(CrossW'(prod_ff.xy) - CrossW'(prod_ff.yx));
            state_in   = S_NRD;
         end
         S_NRD: begin
            state_in = S_NWR;
         end
         S_NWR: begin
            // Write lands before the next corner's read, so repeated corners chain.
            nrm_wr_en = 1'b1;
            if (corner_ff == 2'd2) begin
               state_in = S_IDLE;
            end else begin
               corner_in = corner_ff + 2'd1;
               state_in  = S_NRD;
            end
         end
         S_RRSP: begin
            // Hold here while the result register is full; the read repeats.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (in_range(req_ff.first_index)) begin
                  rsp_data_in = '{normal_x: nrm_rd.x, normal_y: nrm_rd.y,
                                  normal_z: nrm_rd.z};
               end else begin
                  rsp_data_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         corner_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      v1_ff       <= v1_in;
      v2_ff       <= v2_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      prod_ff     <= prod_in;
      cross_ff    <= cross_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mvna_ram #(
      .Width($bits(vtx_type)),
      .Depth(MAX_VERTICES)
   ) u_vtx_ram (
      .clock  (clock),
      .wr_en  (vtx_wr_en),
      .wr_addr(to_addr(req_ff.first_index)),
      .wr_data(vtx_wr),
      .rd_addr(vtx_rd_addr),
      .rd_data(vtx_rd_raw)
   );

   mvna_ram #(
      .Width($bits(norm_type)),
      .Depth(MAX_VERTICES)
   ) u_nrm_ram (
      .clock  (clock),
      .wr_en  (nrm_wr_en),
      .wr_addr(nrm_addr),
      .wr_data(nrm_wr),
      .rd_addr(nrm_addr),
      .rd_data(nrm_rd_raw)
   );

endmodule

`default_nettype wire
